[rtl/core/otsp_pkg.sv]
// Shared types and constants of the one-shot timer pool.
`default_nettype none
package otsp_pkg;

	localparam int MODE_W  = 3;
	localparam int IDX_W   = 3;
	localparam int DELAY_W = 32;
	localparam int KIND_W  = 2;
	localparam int STAMP_W = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_QUERY = 3'd3,
		MODE_SETEL = 3'd4,
		MODE_TICK  = 3'd5
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_RESP      = 2'd0,
		KIND_EXPIRY    = 2'd1,
		KIND_TICK_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_CLOSE = 2'd2
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  which_timer;
		logic              ok;
		logic              started;
		logic              elapsed;
		logic              last;
	} res_t;

endpackage
`default_nettype wire

[rtl/core/otsp_if.sv]
// Valid/ready channel interfaces for the command and result words.
`default_nettype none
interface otsp_op_if;
	import otsp_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [IDX_W-1:0]   timer_index;
	logic [DELAY_W-1:0] delay_ms;

	modport source (output valid, mode, timer_index, delay_ms, input ready);
	modport sink   (input valid, mode, timer_index, delay_ms, output ready);
endinterface

interface otsp_res_if;
	import otsp_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  which_timer;
	logic              ok;
	logic              started;
	logic              elapsed;
	logic              last;

	modport source (output valid, kind, which_timer, ok, started, elapsed, last,
		input ready);
	modport sink   (input valid, kind, which_timer, ok, started, elapsed, last,
		output ready);
endinterface
`default_nettype wire

[rtl/core/one_shot_timer_pool_top.sv]
// Top level of the one-shot timer pool: command decode, tick scan and result register.
//
// The block keeps NUM_TIMERS one-shot timers and a 32-bit tick counter. Commands arrive
// as words on the op channel (valid/ready); every command yields one or more result
// words on the res channel, the final one flagged by last.
// Allocate, start, stop, query and set-elapsed act on per-timer flags held in flops and
// answer with one response word that is visible the cycle after the command is taken.
// A new command can be taken in every cycle while the receiver keeps up and no tick runs.
// A tick bumps the counter, then walks the timers one per cycle, while the receiver keeps
// up, through the stamp RAM (start stamp and timeout, synchronous read). Each timer that
// fires yields an expiry word; a closing word ends the tick. The closing word follows the
// scan of the last timer, and the next command is taken only once the closing word has
// been loaded into the result register; the walk over the RAM read port sets that pace.
// The result register decouples the two sides: a command is accepted while a finished
// word still waits, as long as that word is taken in the same cycle. If the receiver
// stalls, the word holds, the scan pauses on the next timer that fires and the closing
// word waits.
// Reset clears all flags, the tick counter and the scan control. The RAM contents are
// not cleared; only an armed timer's entry can fire it, and only start arms a timer.
`default_nettype none
module one_shot_timer_pool_top #(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	otsp_op_if.sink    op,
	otsp_res_if.source res
);
	import otsp_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int XW = IW + IDX_W;

	// Timer flags and the tick counter.
	logic [NUM_TIMERS-1:0] in_use_q, armed_q, expired_q;
	logic [NUM_TIMERS-1:0] in_use_d, armed_d, expired_d;
	logic [STAMP_W-1:0]    time_now_q;
	logic [STAMP_W-1:0]    time_now_d;

	state_t         state_q, state_d;
	logic [IW-1:0]  scan_idx_q, scan_idx_d;

	res_t res_q, res_d;
	logic res_valid_q;
	logic res_load;
	logic out_free;
	logic op_fire;

	// Stamp RAM ports.
	logic                 ram_wr_en;
	logic [2*STAMP_W-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [IW-1:0]        ram_rd_addr;
	logic [2*STAMP_W-1:0] ram_rd_data;
	logic [STAMP_W-1:0]   rd_stamp, rd_timeout, age;

	// Command decode helpers.
	logic [XW-1:0] idx_x;
	logic [IW-1:0] idx_w;
	logic          idx_ok;
	logic [IW-1:0] alloc_idx;
	logic [XW-1:0] alloc_x;
	logic          alloc_found;
	logic          fire;
	logic          scan_last;
	logic          scan_stall;

	assign out_free = !res_valid_q || res.ready;
	assign op.ready = (state_q == ST_IDLE) && out_free;
	assign op_fire  = op.valid && op.ready;

	assign idx_x  = XW'(op.timer_index);
	assign idx_ok = idx_x < XW'(NUM_TIMERS);
	assign idx_w  = idx_x[IW-1:0];

	// Lowest free timer.
	always_comb begin
		alloc_idx   = '0;
		alloc_found = 1'b0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				alloc_idx   = IW'(i);
				alloc_found = 1'b1;
			end
		end
	end
	assign alloc_x = XW'(alloc_idx);

	// Expiry check on the timer whose stamps sit in the RAM output register.
	assign rd_stamp   = ram_rd_data[2*STAMP_W-1:STAMP_W];
	assign rd_timeout = ram_rd_data[STAMP_W-1:0];
	assign age        = time_now_q - rd_stamp;
	assign fire       = in_use_q[scan_idx_q] && armed_q[scan_idx_q] &&
		!expired_q[scan_idx_q] && (age > rd_timeout);
	assign scan_last  = scan_idx_q == IW'(NUM_TIMERS - 1);
	assign scan_stall = fire && !out_free;

	otsp_stamp_ram #(
		.DEPTH (NUM_TIMERS),
		.AW    (IW)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (idx_w),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (op_fire && op.mode == MODE_TICK) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!scan_stall && scan_last) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath control and result formation.
	always_comb begin
		in_use_d    = in_use_q;
		armed_d     = armed_q;
		expired_d   = expired_q;
		time_now_d  = time_now_q;
		scan_idx_d  = scan_idx_q;
		ram_wr_en   = 1'b0;
		ram_wr_data = {time_now_q, op.delay_ms};
		ram_rd_en   = 1'b0;
		ram_rd_addr = scan_idx_q;
		res_load    = 1'b0;
		res_d       = res_q;
		case (state_q)
			ST_IDLE: begin
				if (op_fire) begin
					res_d = '{kind: KIND_RESP, which_timer: op.timer_index, ok: 1'b0,
						started: 1'b0, elapsed: 1'b0, last: 1'b1};
					case (mode_t'(op.mode))
						MODE_ALLOC: begin
							res_load = 1'b1;
							if (alloc_found) begin
								in_use_d[alloc_idx] = 1'b1;
								res_d.which_timer   = alloc_x[IDX_W-1:0];
								res_d.ok            = 1'b1;
								res_d.started       = armed_q[alloc_idx];
								res_d.elapsed       = expired_q[alloc_idx];
							end else begin
								res_d.which_timer = '0;
							end
						end
						MODE_START: begin
							res_load = 1'b1;
							if (idx_ok) begin
								if (in_use_q[idx_w]) begin
									armed_d[idx_w]   = 1'b1;
									expired_d[idx_w] = 1'b0;
									ram_wr_en        = 1'b1;
									res_d.ok         = 1'b1;
								end
								res_d.started = armed_d[idx_w];
								res_d.elapsed = expired_d[idx_w];
							end
						end
						MODE_STOP: begin
							res_load = 1'b1;
							if (idx_ok) begin
								armed_d[idx_w]   = 1'b0;
								expired_d[idx_w] = 1'b0;
							end
						end
						MODE_QUERY: begin
							res_load = 1'b1;
							if (idx_ok) begin
								res_d.started = armed_q[idx_w];
								res_d.elapsed = expired_q[idx_w];
							end
						end
						MODE_SETEL: begin
							res_load = 1'b1;
							if (idx_ok) begin
								expired_d[idx_w] = 1'b1;
								res_d.started    = armed_q[idx_w];
								res_d.elapsed    = 1'b1;
							end
						end
						MODE_TICK: begin
							time_now_d  = time_now_q + STAMP_W'(1);
							scan_idx_d  = '0;
							ram_rd_en   = 1'b1;
							ram_rd_addr = '0;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!scan_stall) begin
					if (fire) begin
						armed_d[scan_idx_q]   = 1'b0;
						expired_d[scan_idx_q] = 1'b1;
						res_load              = 1'b1;
						res_d = '{kind: KIND_EXPIRY,
							which_timer: IDX_W'(XW'(scan_idx_q)),
							ok: 1'b0, started: 1'b0, elapsed: 1'b1, last: 1'b0};
					end
					if (!scan_last) begin
						scan_idx_d  = scan_idx_q + IW'(1);
						ram_rd_en   = 1'b1;
						ram_rd_addr = scan_idx_q + IW'(1);
					end
				end
			end
			ST_CLOSE: begin
				if (out_free) begin
					res_load = 1'b1;
					res_d = '{kind: KIND_TICK_DONE, which_timer: '0, ok: 1'b0,
						started: 1'b0, elapsed: 1'b0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_use_q    <= '0;
			armed_q     <= '0;
			expired_q   <= '0;
			time_now_q  <= '0;
			scan_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_use_q   <= in_use_d;
			armed_q    <= armed_d;
			expired_q  <= expired_d;
			time_now_q <= time_now_d;
			scan_idx_q <= scan_idx_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.kind        = res_q.kind;
	assign res.which_timer = res_q.which_timer;
	assign res.ok          = res_q.ok;
	assign res.started     = res_q.started;
	assign res.elapsed     = res_q.elapsed;
	assign res.last        = res_q.last;

	// A tick that is taken always starts the scan in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(op.valid && op.ready && op.mode == MODE_TICK) |=> state_q == ST_SCAN)
		else $error("tick accepted without entering the scan");

	// The tick counter moves only on an accepted tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(op.valid && op.ready && op.mode == MODE_TICK) |=> $stable(time_now_q))
		else $error("tick counter moved without a tick");

	// A waiting result word is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !res_load)
		else $error("result word overwritten while stalled");

	// Expiry words never close an item and always report the elapsed flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_EXPIRY) |-> (!res.last && res.elapsed))
		else $error("malformed expiry word");

endmodule
`default_nettype wire

[rtl/core/otsp_stamp_ram.sv]
// Simple dual-port RAM holding each timer's start stamp and timeout.
`default_nettype none
module otsp_stamp_ram #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [2*otsp_pkg::STAMP_W-1:0] wr_data,
	input  wire logic                          rd_en,
	input  wire logic [AW-1:0]                 rd_addr,
	output      logic [2*otsp_pkg::STAMP_W-1:0] rd_data
);
	import otsp_pkg::*;

	logic [2*STAMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the one-shot timer pool: random command traffic, scoreboard.
module tb;
	import otsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TIMERS = 8;

	// Modes 6 and 7 have no function; the block must still answer them.
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	// The longest quiet spell in a correct run is a tick scan plus a random stall
	// from draw_gap on either side. This limit is far above that.
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = NUM_TIMERS + 6;
	localparam int RANDOM_WORDS = 235;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [IDX_W-1:0]   timer_index;
		logic [DELAY_W-1:0] delay_ms;
	} cmd_word_t;

	logic clk;
	logic arst_n;

	otsp_op_if  op_ch ();
	otsp_res_if res_ch ();

	one_shot_timer_pool_top #(.NUM_TIMERS(NUM_TIMERS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_ch),
		.res    (res_ch)
	);

	// Command words waiting to be driven, and result words the timer bank owes us.
	cmd_word_t cmd_backlog[$];
	res_t      owed_results[$];

	// Our own copy of the timer bank, advanced once per accepted command word.
	logic                timer_in_use [NUM_TIMERS];
	logic                timer_armed  [NUM_TIMERS];
	logic                timer_fired  [NUM_TIMERS];
	logic [STAMP_W-1:0]  armed_at     [NUM_TIMERS];
	logic [DELAY_W-1:0]  armed_for    [NUM_TIMERS];
	logic [STAMP_W-1:0]  tick_count;

	int cmds_taken;
	int results_taken;
	int mismatches;
	int quiet_cycles;
	int cmd_gap;
	int res_gap;

	function automatic res_t make_result(kind_t kind, logic [IDX_W-1:0] which, logic ok,
		logic started, logic elapsed, logic last);
		res_t w;
		w.kind        = kind;
		w.which_timer = which;
		w.ok          = ok;
		w.started     = started;
		w.elapsed     = elapsed;
		w.last        = last;
		return w;
	endfunction

	// Every so often a side runs flat out for a stretch of 40 words, so that
	// back-to-back traffic is covered as well as random gaps.
	function automatic int draw_gap(int words_so_far);
		if ((words_so_far / 40) % 3 == 2)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Advance the timer bank by one command and queue the result words it owes.
	task automatic timer_bank_step(input cmd_word_t c);
		logic found;
		logic ok;
		int   i;
		found = 1'b0;
		ok    = 1'b0;
		case (c.mode)
			MODE_ALLOC: begin
				// Lowest free timer wins. Allocation is never undone.
				for (i = 0; i < NUM_TIMERS; i++) begin
					if (!found && !timer_in_use[i]) begin
						found           = 1'b1;
						timer_in_use[i] = 1'b1;
						owed_results.push_back(make_result(KIND_RESP, IDX_W'(i), 1'b1,
							timer_armed[i], timer_fired[i], 1'b1));
					end
				end
				// Pool exhausted: flagged by ok low, index and flags all zero.
				if (!found)
					owed_results.push_back(make_result(KIND_RESP, '0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			MODE_TICK: begin
				tick_count = tick_count + 1'b1;
				for (i = 0; i < NUM_TIMERS; i++) begin
					// The difference wraps at 32 bits, just like the counter.
					if (timer_in_use[i] && timer_armed[i] && !timer_fired[i] &&
						STAMP_W'(tick_count - armed_at[i]) > armed_for[i]) begin
						timer_armed[i] = 1'b0;
						timer_fired[i] = 1'b1;
						owed_results.push_back(make_result(KIND_EXPIRY, IDX_W'(i), 1'b0,
							1'b0, 1'b1, 1'b0));
					end
				end
				owed_results.push_back(make_result(KIND_TICK_DONE, '0, 1'b0, 1'b0, 1'b0, 1'b1));
			end
			MODE_START, MODE_STOP, MODE_QUERY, MODE_SETEL: begin
				if (c.mode == MODE_START && timer_in_use[c.timer_index]) begin
					timer_armed[c.timer_index] = 1'b1;
					timer_fired[c.timer_index] = 1'b0;
					armed_at[c.timer_index]    = tick_count;
					armed_for[c.timer_index]   = c.delay_ms;
					ok = 1'b1;
				end
				// Stop and set-elapsed touch the flags even on a free timer.
				if (c.mode == MODE_STOP) begin
					timer_armed[c.timer_index] = 1'b0;
					timer_fired[c.timer_index] = 1'b0;
				end
				if (c.mode == MODE_SETEL)
					timer_fired[c.timer_index] = 1'b1;
				owed_results.push_back(make_result(KIND_RESP, c.timer_index, ok,
					timer_armed[c.timer_index], timer_fired[c.timer_index], 1'b1));
			end
			default: begin
				// Spare modes answer with the index and nothing else.
				owed_results.push_back(make_result(KIND_RESP, c.timer_index, 1'b0, 1'b0,
					1'b0, 1'b1));
			end
		endcase
	endtask

	task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
		input logic [DELAY_W-1:0] delay);
		cmd_word_t c;
		c.mode        = mode;
		c.timer_index = idx;
		c.delay_ms    = delay;
		cmd_backlog.push_back(c);
	endtask

	// Clock and the single reset pulse. Inputs of the block are given known
	// values at time zero, before the reset branch of the driver first runs.
	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		op_ch.valid          = 1'b0;
		op_ch.mode           = '0;
		op_ch.timer_index    = '0;
		op_ch.delay_ms       = '0;
		res_ch.ready         = 1'b0;
		fork
			forever #2 clk = ~clk;
		join_none
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Command driver. A word is taken on the rising edge where valid and ready
	// are both high; the model is advanced on that same edge. After each word the
	// driver holds valid low for a randomly drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_ch.valid       <= 1'b0;
			op_ch.mode        <= '0;
			op_ch.timer_index <= '0;
			op_ch.delay_ms    <= '0;
			cmd_gap           <= 0;
		end else begin
			if (op_ch.valid && op_ch.ready) begin
				timer_bank_step('{op_ch.mode, op_ch.timer_index, op_ch.delay_ms});
				cmds_taken <= cmds_taken + 1;
			end
			if (!op_ch.valid || op_ch.ready) begin
				if (cmd_gap != 0) begin
					op_ch.valid <= 1'b0;
					cmd_gap     <= cmd_gap - 1;
				end else if (cmd_backlog.size() != 0) begin
					cmd_word_t c;
					c = cmd_backlog.pop_front();
					op_ch.valid       <= 1'b1;
					op_ch.mode        <= c.mode;
					op_ch.timer_index <= c.timer_index;
					op_ch.delay_ms    <= c.delay_ms;
					cmd_gap           <= draw_gap(cmds_taken);
				end else begin
					op_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Each word taken is checked field by field against the
	// oldest owed result. Ready drops for a random stall after each word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			res_gap      <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				res_t want;
				int   stall;
				results_taken <= results_taken + 1;
				if (owed_results.size() == 0) begin
					mismatches <= mismatches + 1;
					$display({"%0t: expected no word, actual kind=%0d which=%0d ok=%0b",
						" st=%0b el=%0b last=%0b"},
						$time, res_ch.kind, res_ch.which_timer, res_ch.ok,
						res_ch.started, res_ch.elapsed, res_ch.last);
				end else begin
					want = owed_results.pop_front();
					if (want.kind !== res_ch.kind || want.which_timer !== res_ch.which_timer ||
						want.ok !== res_ch.ok || want.started !== res_ch.started ||
						want.elapsed !== res_ch.elapsed || want.last !== res_ch.last) begin
						mismatches <= mismatches + 1;
						$display({"%0t: expected kind=%0d which=%0d ok=%0b st=%0b el=%0b",
							" last=%0b, actual kind=%0d which=%0d ok=%0b st=%0b el=%0b",
							" last=%0b"},
							$time, want.kind, want.which_timer, want.ok, want.started,
							want.elapsed, want.last, res_ch.kind, res_ch.which_timer,
							res_ch.ok, res_ch.started, res_ch.elapsed, res_ch.last);
					end
				end
				stall = draw_gap(results_taken);
				if (stall != 0) begin
					res_ch.ready <= 1'b0;
					res_gap      <= stall - 1;
				end
			end else if (res_gap != 0) begin
				res_gap <= res_gap - 1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run that goes quiet for too long has hung or lost a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int t;
		int pick;
		int added;
		logic [DELAY_W-1:0] delay;

		for (i = 0; i < NUM_TIMERS; i++) begin
			timer_in_use[i] = 1'b0;
			timer_armed[i]  = 1'b0;
			timer_fired[i]  = 1'b0;
			armed_at[i]     = '0;
			armed_for[i]    = '0;
		end
		tick_count    = '0;
		cmds_taken    = 0;
		results_taken = 0;
		mismatches    = 0;
		quiet_cycles  = 0;

		// Directed opening. Before anything is allocated: a query, a start that
		// must be refused, flag updates on free timers, the spare modes and an
		// empty tick.
		queue_cmd(MODE_QUERY, 3'd7, '0);
		queue_cmd(MODE_START, 3'd2, 32'd5);
		queue_cmd(MODE_SETEL, 3'd6, '0);
		queue_cmd(MODE_STOP, 3'd5, '1);
		queue_cmd(MODE_SPARE6, 3'd3, 32'h0000_ffff);
		queue_cmd(MODE_SPARE7, 3'd7, '1);
		queue_cmd(MODE_TICK, 3'd4, '0);
		// Zero delay fires on the first tick after the start; the all-ones delay
		// can never fire, and is then forced elapsed and re-armed.
		queue_cmd(MODE_ALLOC, 3'd5, '0);
		queue_cmd(MODE_START, 3'd0, '0);
		queue_cmd(MODE_ALLOC, '0, '0);
		queue_cmd(MODE_START, 3'd1, '1);
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_SETEL, 3'd1, '0);
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_START, 3'd1, 32'd1);
		queue_cmd(MODE_QUERY, 3'd1, '0);
		// Fill the pool; timer 6 still carries its forced elapsed flag. The ninth
		// allocation has to fail.
		for (i = 0; i < NUM_TIMERS - 1; i++)
			queue_cmd(MODE_ALLOC, IDX_W'($urandom), '0);
		// Timer 1 must wait until the difference exceeds its delay, not equals it.
		queue_cmd(MODE_TICK, '0, '0);
		queue_cmd(MODE_TICK, '0, '0);

		// Random traffic. Most starts carry short delays so that timers really
		// fire within the run; a share carry full 32-bit values. Now and then
		// every timer is started with a zero delay so one tick fires them all.
		added = 0;
		while (added < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			t    = $urandom_range(0, 99);
			if (t < 70)
				delay = DELAY_W'($urandom_range(0, 6));
			else if (t < 85)
				delay = DELAY_W'($urandom_range(0, 40));
			else
				delay = $urandom;
			if (pick < 4) begin
				for (i = 0; i < NUM_TIMERS; i++)
					queue_cmd(MODE_START, IDX_W'(i), '0);
				queue_cmd(MODE_TICK, IDX_W'($urandom), $urandom);
				added += NUM_TIMERS + 1;
			end else begin
				if (pick < 34)
					queue_cmd(MODE_TICK, IDX_W'($urandom), $urandom);
				else if (pick < 60)
					queue_cmd(MODE_START, IDX_W'($urandom), delay);
				else if (pick < 70)
					queue_cmd(MODE_STOP, IDX_W'($urandom), $urandom);
				else if (pick < 81)
					queue_cmd(MODE_QUERY, IDX_W'($urandom), $urandom);
				else if (pick < 89)
					queue_cmd(MODE_SETEL, IDX_W'($urandom), $urandom);
				else if (pick < 95)
					queue_cmd(MODE_ALLOC, IDX_W'($urandom), $urandom);
				else if (pick < 98)
					queue_cmd(MODE_SPARE6, IDX_W'($urandom), $urandom);
				else
					queue_cmd(MODE_SPARE7, IDX_W'($urandom), $urandom);
				added++;
			end
		end

		// Wait for the backlog to drain and every owed word to arrive, then give
		// the block a scan's worth of cycles to show any extra word.
		@(posedge arst_n);
		while (cmd_backlog.size() != 0 || op_ch.valid || owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
